// ===== hdl/stsp_pkg.sv =====
// Shared types, constants and keyword matcher for the source token spacer.
`timescale 1ns / 1ps
`default_nettype none

package stsp_pkg;

  // Lookahead window: six bytes cover the longest keyword.
  localparam int LookaheadDepth = 6;
  localparam int MatchSpan      = 6;
  localparam int WinDepth       = (LookaheadDepth < MatchSpan) ? LookaheadDepth : MatchSpan;
  localparam int CntW           = $clog2(WinDepth + 1);
  localparam int IdxW           = $clog2(WinDepth);

  // Command queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  // Byte codes with a special role.
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace   = 8'd32;
  localparam logic [7:0] ChSlash   = 8'h2f;

  typedef logic [WinDepth-1:0][7:0] win_t;

  // One output unit: an optional leading space, then len bytes of the window.
  typedef struct packed {
    logic            last;
    logic            sep;
    logic [CntW-1:0] len;
    win_t            bytes;
  } cmd_t;

  // All whitespace bytes other than the line end are treated alike.
  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13) || (c == 8'd32);
  endfunction

  // Length of the longest keyword at the head of the window, zero if none.
  // Later checks are longer keywords and override earlier ones.
  function automatic logic [CntW-1:0] kw_len(win_t w, logic [CntW-1:0] n);
    logic [CntW-1:0] r;
    r = '0;
    if (n >= CntW'(1)) begin
      case (w[0])
        "=", "+", "-", "*", "/", "%", ">", "<", "!", ",", ";", "(", ")", "{", "}": begin
          r = CntW'(1);
        end
        default: begin
          r = '0;
        end
      endcase
    end
    if ((n >= CntW'(2)) && ((w[1:0] == {"&", "&"}) || (w[1:0] == {"|", "|"}))) begin
      r = CntW'(2);
    end
    if ((n >= CntW'(3)) && ((w[2:0] == {"r", "o", "f"}) || (w[2:0] == {"t", "n", "i"}))) begin
      r = CntW'(3);
    end
    if ((n >= CntW'(5)) && (w[4:0] == {">", ">", "n", "i", "c"})) begin
      r = CntW'(5);
    end
    if ((n >= CntW'(6)) && (w[5:0] == {"<", "<", "t", "u", "o", "c"})) begin
      r = CntW'(6);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/source_token_spacer.sv =====
// Top level of the source token spacer: front end, command queue and byte output stage.
// A byte that completes a window decision passes through the command queue and the output register.
// Input: one byte per cycle while the queue has room; a line end holds off input while the front
// end's unit makes the head decisions on the still-buffered bytes (up to five) and issues the newline.
// Output: one byte per cycle from the back end while the receiver is ready; a command gives up to seven bytes.
// Reset is asynchronous and active low; it clears all control state, window bytes are not reset.
`timescale 1ns / 1ps
`default_nettype none

module source_token_spacer (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_tvalid_i,
  output logic       s_tready_o,
  input  wire  [7:0] s_tdata_i,   // [7:0] in_char
  input  wire  [0:0] s_tuser_i,   // [0] end_of_stream
  output logic       m_tvalid_o,
  input  wire        m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] out_char
  output logic       m_tlast_o
);
  import stsp_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, full, pop, empty;

  // Front end: window and classification.
  stsp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .in_char_i  (s_tdata_i),
    .in_eos_i   (s_tuser_i[0]),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  // Command queue.
  stsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty)
  );

  // Back end: byte serializer and output register.
  stsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_char_o  (m_tdata_o),
    .out_last_o  (m_tlast_o)
  );

endmodule

`default_nettype wire

// ===== hdl/stsp_fifo.sv =====
// Short command queue that decouples the classifying front from the output back.
`timescale 1ns / 1ps
`default_nettype none

module stsp_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  stsp_pkg::cmd_t      data_i,
  output logic                full_o,
  input  wire                 pop_i,
  output stsp_pkg::cmd_t      head_o,
  output logic                empty_o
);
  import stsp_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (QPtrW + 1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPtrW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stsp_front.sv =====
// Front end: takes input bytes, runs the lookahead window and issues output commands.
`timescale 1ns / 1ps
`default_nettype none

module stsp_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [7:0]          in_char_i,
  input  wire                 in_eos_i,
  output logic                push_o,
  output stsp_pkg::cmd_t      cmd_o,
  input  wire                 full_i
);
  import stsp_pkg::*;

  localparam logic StRun   = 1'b0;
  localparam logic StFlush = 1'b1;

  logic            state_q, state_d;
  win_t            win_q, win_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            emit_q, emit_d;
  logic            code_q, code_d;
  logic            cmt_q, cmt_d;
  logic            nonempty_q, nonempty_d;

  // Head decision signals.
  win_t            hw;
  logic [CntW-1:0] hn;
  logic [CntW-1:0] h_len, h_drop;
  logic            h_comment, h_kw, h_ws, h_push;
  cmd_t            h_cmd, nl_cmd;
  win_t            hd_win;
  logic [CntW-1:0] hd_cnt;
  logic            hd_pend, hd_emit, hd_code, hd_cmt;
  logic            accept;

  assign in_ready_o = (state_q == StRun) && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // While running, the head sees the stored bytes plus the arriving one;
  // while flushing, it sees the stored bytes alone.
  always_comb begin
    hw = win_q;
    hn = cnt_q;
    if (state_q == StRun) begin
      hw[WinDepth-1] = in_char_i;
      hn             = CntW'(WinDepth);
    end
  end

  // Classification of the window head.
  assign h_comment = (hw[0] == ChSlash) && (hn >= CntW'(2)) && (hw[1] == ChSlash);
  assign h_len     = kw_len(hw, hn);
  assign h_kw      = (h_len != '0);
  assign h_ws      = is_ws(hw[0]);
  assign h_push    = !h_comment && (h_kw || !h_ws);
  assign h_drop    = h_kw ? h_len : CntW'(1);

  always_comb begin
    h_cmd.last  = (state_q == StRun);
    h_cmd.sep   = h_kw ? emit_q : (pend_q && emit_q);
    h_cmd.len   = h_drop;
    h_cmd.bytes = hw;

    nl_cmd          = '0;
    nl_cmd.last     = 1'b1;
    nl_cmd.len      = CntW'(1);
    nl_cmd.bytes[0] = ChNewline;
  end

  // State after the head is taken.
  always_comb begin
    hd_win  = win_t'(hw >> {h_drop, 3'b000});
    hd_cnt  = hn - h_drop;
    hd_pend = pend_q;
    hd_emit = emit_q;
    hd_code = code_q;
    hd_cmt  = cmt_q;
    if (h_comment) begin
      hd_win = hw;
      hd_cnt = '0;
      hd_cmt = 1'b1;
    end else if (h_kw) begin
      hd_pend = 1'b1;
      hd_emit = 1'b1;
      hd_code = 1'b1;
    end else if (h_ws) begin
      hd_pend = 1'b1;
    end else begin
      hd_pend = 1'b0;
      hd_emit = 1'b1;
      hd_code = 1'b1;
    end
  end

  // Sequencing of bytes and line ends.
  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    emit_d     = emit_q;
    code_d     = code_q;
    cmt_d      = cmt_q;
    nonempty_d = nonempty_q;
    push_o     = 1'b0;
    cmd_o      = h_cmd;

    case (state_q)
      StRun: begin
        if (accept) begin
          if (in_eos_i) begin
            if (nonempty_q) begin
              state_d = StFlush;
            end
          end else if (in_char_i == ChNewline) begin
            state_d = StFlush;
          end else begin
            nonempty_d = 1'b1;
            if (!cmt_q) begin
              if (cnt_q == CntW'(WinDepth - 1)) begin
                push_o = h_push;
                win_d  = hd_win;
                cnt_d  = hd_cnt;
                pend_d = hd_pend;
                emit_d = hd_emit;
                code_d = hd_code;
                cmt_d  = hd_cmt;
              end else begin
                win_d[cnt_q[IdxW-1:0]] = in_char_i;
                cnt_d                  = cnt_q + CntW'(1);
              end
            end
          end
        end
      end
      StFlush: begin
        if (!full_i) begin
          if ((cnt_q != '0) && !cmt_q) begin
            push_o = h_push;
            win_d  = hd_win;
            cnt_d  = hd_cnt;
            pend_d = hd_pend;
            emit_d = hd_emit;
            code_d = hd_code;
            cmt_d  = hd_cmt;
          end else begin
            push_o     = !(cmt_q && !code_q);
            cmd_o      = nl_cmd;
            cnt_d      = '0;
            pend_d     = 1'b0;
            emit_d     = 1'b0;
            code_d     = 1'b0;
            cmt_d      = 1'b0;
            nonempty_d = 1'b0;
            state_d    = StRun;
          end
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StRun;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
      emit_q     <= 1'b0;
      code_q     <= 1'b0;
      cmt_q      <= 1'b0;
      nonempty_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_q     <= pend_d;
      emit_q     <= emit_d;
      code_q     <= code_d;
      cmt_q      <= cmt_d;
      nonempty_q <= nonempty_d;
    end
  end

  // Window bytes are only read below the fill count.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // The window never holds a full set of bytes between transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < CntW'(WinDepth))
    else $error("lookahead count out of range");

  // Inside a comment nothing remains buffered.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmt_q |-> (cnt_q == '0))
    else $error("bytes buffered inside a comment");

  // No new byte is taken while a line is being finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == StFlush) |-> !in_ready_o)
    else $error("input accepted during line flush");

  // Commands are only issued when the queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> !full_i)
    else $error("command issued into a full queue");

endmodule

`default_nettype wire

// ===== hdl/stsp_back.sv =====
// Back end: expands queued commands into output bytes, one per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module stsp_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  stsp_pkg::cmd_t      cmd_i,
  input  wire                 empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [7:0]          out_char_o,
  output logic                out_last_o
);
  import stsp_pkg::*;

  logic            valid_q, valid_d;
  logic [7:0]      char_q, char_d;
  logic            last_q, last_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CntW-1:0] eff;
  logic            slot_free, emit;

  assign slot_free   = !valid_q || out_ready_i;
  assign emit        = slot_free && !empty_i;
  // Step zero is the separator; skip it when the command has none.
  assign eff         = ((step_q == '0) && !cmd_i.sep) ? CntW'(1) : step_q;
  assign pop_o       = emit && (eff == cmd_i.len);
  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  // Output register load.
  always_comb begin
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    step_d  = step_q;
    if (slot_free) begin
      valid_d = !empty_i;
    end
    if (emit) begin
      char_d = (eff == '0) ? ChSpace : cmd_i.bytes[IdxW'(eff - CntW'(1))];
      last_d = cmd_i.last && (eff == cmd_i.len);
      step_d = (eff == cmd_i.len) ? '0 : eff + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire

// ===== bench/tb_source_token_spacer.sv =====
// Self-checking testbench for the source token spacer: directed table, random lines, predictor.
`timescale 1ns / 1ps

module tb_source_token_spacer;

  import stsp_pkg::ChNewline;
  import stsp_pkg::ChSpace;
  import stsp_pkg::ChSlash;
  import stsp_pkg::MatchSpan;

  localparam int ItemsTarget = 350;
  localparam int MaxPerItem  = 16;
  // A line end can release eleven bytes while the receiver stalls 79 percent of the time;
  // the limit is set many times over the quiet stretch that this can cause.
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;

  // One output byte together with its end-of-item marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  // One row of the directed table; typed rows carry their result in the row itself.
  typedef struct {
    logic [7:0] ch;
    logic       eos;
    bit         typed;
    int         n_typed;
    logic [7:0] typed_ch;
  } dir_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       s_tvalid   = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata    = '0;
  logic [0:0] s_tuser    = '0;
  logic       m_tvalid;
  logic       m_tready   = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int send_idle_pct = 13;
  int recv_idle_pct = 79;
  int items_sent    = 0;
  int mismatch_cnt  = 0;
  int quiet_cycles  = 0;

  // Keywords in the order they are tried, longest first.
  string kw_set [21] = '{"cout<<", "cin>>", "for", "int", "&&", "||", "=", "+", "-", "*",
                         "/", "%", ">", "<", "!", ",", ";", "(", ")", "{", "}"};
  string ident_pool  = "coutinfrxyz_09AB";

  // Spacer state as the predictor tracks it.
  logic [7:0] win_bytes [MatchSpan];
  int         win_cnt     = 0;
  bit         sep_pending = 1'b0;
  bit         emitted_ln  = 1'b0;
  bit         code_ln     = 1'b0;
  bit         in_cmt      = 1'b0;
  bit         line_used   = 1'b0;

  out_byte_t  step_bytes [$];
  out_byte_t  expected_bytes [$];
  out_byte_t  want;

  dir_row_t dir_rows [25] = '{
    '{8'hA5, 1'b1, 1'b1, 0, 8'h00},       // flush right after reset releases nothing
    '{ChNewline, 1'b0, 1'b1, 1, ChNewline}, // an empty line is kept as a bare newline
    '{"c", 1'b0, 1'b0, 0, 8'h00},
    '{"o", 1'b0, 1'b0, 0, 8'h00},
    '{"u", 1'b0, 1'b0, 0, 8'h00},
    '{"t", 1'b0, 1'b0, 0, 8'h00},
    '{"<", 1'b0, 1'b0, 0, 8'h00},
    '{"<", 1'b0, 1'b0, 0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 0, 8'h00},
    '{8'h0D, 1'b0, 1'b0, 0, 8'h00},
    '{ChSlash, 1'b0, 1'b0, 0, 8'h00},
    '{ChSlash, 1'b0, 1'b0, 0, 8'h00},
    '{"z", 1'b0, 1'b0, 0, 8'h00},
    '{ChNewline, 1'b0, 1'b0, 0, 8'h00},
    '{ChSpace, 1'b0, 1'b0, 0, 8'h00},
    '{ChSlash, 1'b0, 1'b0, 0, 8'h00},
    '{ChSlash, 1'b0, 1'b0, 0, 8'h00},
    '{ChNewline, 1'b0, 1'b1, 0, 8'h00},     // a full-line comment drops its newline too
    '{"i", 1'b0, 1'b0, 0, 8'h00},
    '{"n", 1'b0, 1'b0, 0, 8'h00},
    '{"t", 1'b0, 1'b0, 0, 8'h00},
    '{"&", 1'b0, 1'b0, 0, 8'h00},
    '{"&", 1'b0, 1'b0, 0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 0, 8'h00}
  };

  source_token_spacer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic bit is_blank(logic [7:0] c);
    return (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13) || (c == ChSpace);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return 8'd9;
      1:       return 8'd11;
      2:       return 8'd12;
      3:       return 8'd13;
      default: return ChSpace;
    endcase
  endfunction

  // Length of the first keyword that matches the head of the window, zero if none.
  function automatic int head_keyword_len();
    int k;
    int i;
    int len;
    bit hit;
    for (k = 0; k < 21; k++) begin
      len = kw_set[k].len();
      if (len <= win_cnt) begin
        hit = 1'b1;
        for (i = 0; i < len; i++) begin
          if (win_bytes[i] != kw_set[k].getc(i)) hit = 1'b0;
        end
        if (hit) return len;
      end
    end
    return 0;
  endfunction

  task automatic emit(logic [7:0] c);
    if (step_bytes.size() < MaxPerItem) step_bytes.push_back('{c, 1'b0});
  endtask

  task automatic drop_head(int k);
    int i;
    if (k >= win_cnt) begin
      win_cnt = 0;
    end else begin
      for (i = 0; i + k < win_cnt; i++) win_bytes[i] = win_bytes[i + k];
      win_cnt = win_cnt - k;
    end
  endtask

  // Decide on the byte or keyword at the head of the window.
  task automatic take_head();
    int len;
    int i;
    logic [7:0] c;
    if (win_cnt == 0) return;
    if (win_bytes[0] == ChSlash && win_cnt >= 2 && win_bytes[1] == ChSlash) begin
      in_cmt  = 1'b1;
      win_cnt = 0;
      return;
    end
    len = head_keyword_len();
    if (len > 0) begin
      if (emitted_ln) emit(ChSpace);
      for (i = 0; i < len; i++) emit(win_bytes[i]);
      emitted_ln  = 1'b1;
      sep_pending = 1'b1;
      code_ln     = 1'b1;
      drop_head(len);
      return;
    end
    c = win_bytes[0];
    if (is_blank(c)) begin
      sep_pending = 1'b1;
    end else begin
      if (sep_pending && emitted_ln) emit(ChSpace);
      emit(c);
      emitted_ln  = 1'b1;
      sep_pending = 1'b0;
      code_ln     = 1'b1;
    end
    drop_head(1);
  endtask

  task automatic clear_line();
    win_cnt     = 0;
    sep_pending = 1'b0;
    emitted_ln  = 1'b0;
    code_ln     = 1'b0;
    in_cmt      = 1'b0;
    line_used   = 1'b0;
  endtask

  // Drain the window at a line end; a line that held only a comment leaves no trace.
  task automatic close_line();
    while (win_cnt > 0 && !in_cmt) take_head();
    if (!(in_cmt && !code_ln)) emit(ChNewline);
    clear_line();
  endtask

  // Work out the bytes that one accepted transaction releases.
  task automatic predict_spacing(logic [7:0] c, logic eos);
    step_bytes.delete();
    if (eos) begin
      if (line_used) close_line();
      else clear_line();
    end else if (c == ChNewline) begin
      close_line();
    end else begin
      line_used = 1'b1;
      if (!in_cmt) begin
        if (win_cnt < MatchSpan) begin
          win_bytes[win_cnt] = c;
          win_cnt++;
        end
        while (win_cnt >= MatchSpan && !in_cmt) take_head();
      end
    end
    if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
  endtask

  task automatic note_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, what);
  endtask

  // Offer one transaction, with random idle cycles ahead of it, and queue its expected bytes.
  task automatic send_item(logic [7:0] c, logic eos, bit typed = 1'b0, int n_typed = 0,
                           logic [7:0] typed_ch = 8'h00);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= eos;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_spacing(c, eos);
    if (typed) begin
      if (n_typed == 1) expected_bytes.push_back('{typed_ch, 1'b1});
    end else begin
      foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
    end
  endtask

  // One random source line: mostly keywords, identifiers and blanks, with comments and noise.
  task automatic send_line();
    int    pieces;
    int    p;
    int    r;
    int    n;
    int    j;
    string kw;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 1) send_item(pick_blank(), 1'b0);
      send_item(ChSlash, 1'b0);
      send_item(ChSlash, 1'b0);
      n = $urandom_range(0, 4);
      for (j = 0; j < n; j++) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      pieces = $urandom_range(0, 6);
      for (p = 0; p < pieces; p++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          kw = kw_set[$urandom_range(0, 20)];
          for (j = 0; j < kw.len(); j++) send_item(kw.getc(j), 1'b0);
        end else if (r < 60) begin
          n = $urandom_range(1, 4);
          for (j = 0; j < n; j++)
            send_item(ident_pool.getc($urandom_range(0, ident_pool.len() - 1)), 1'b0);
        end else if (r < 72) begin
          n = $urandom_range(1, 3);
          for (j = 0; j < n; j++) send_item(pick_blank(), 1'b0);
        end else if (r < 80) begin
          // Broken keyword: a proper prefix of one of the longer ones.
          kw = kw_set[$urandom_range(0, 5)];
          n  = $urandom_range(1, kw.len() - 1);
          for (j = 0; j < n; j++) send_item(kw.getc(j), 1'b0);
        end else if (r < 90) begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 95) begin
          send_item(8'($urandom_range(128, 255)), 1'b0);
        end else begin
          send_item(ChSlash, 1'b0);
          send_item(ChSlash, 1'b0);
          n = $urandom_range(0, 3);
          for (j = 0; j < n; j++) send_item(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
    // Close the line by newline or by a flush; now and then leave it open.
    r = $urandom_range(0, 99);
    if (r < 88) begin
      send_item(ChNewline, 1'b0);
    end else if (r < 96) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
      if ($urandom_range(0, 3) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Receiver side: random back-pressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Output checker against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected output byte 0x%02h last %0b", m_tdata, m_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.ch)
          note_mismatch($sformatf("out_char: expected 0x%02h, got 0x%02h", want.ch, m_tdata));
        if (m_tlast !== want.last)
          note_mismatch($sformatf("last: expected %0b, got %0b (byte 0x%02h)",
                                  want.last, m_tlast, m_tdata));
      end
    end
  end

  // Watchdog on cycles in which neither side moves a transaction.
  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_source_token_spacer failed");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then three idling phases of random lines.
  initial begin
    int ph;
    clear_line();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[k])
      send_item(dir_rows[k].ch, dir_rows[k].eos, dir_rows[k].typed, dir_rows[k].n_typed,
                dir_rows[k].typed_ch);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (items_sent < ItemsTarget * (ph + 1) / 3) send_line();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("tb_source_token_spacer passed");
    end else begin
      $display("tb_source_token_spacer failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/stsp_pkg.sv
hdl/stsp_fifo.sv
hdl/stsp_front.sv
hdl/stsp_back.sv
hdl/source_token_spacer.sv
bench/tb_source_token_spacer.sv
